[hw/rtl/zngs_pkg.sv]
`default_nettype none

package zngs_pkg;

  // Fixed field widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned GEOM_W     = 11;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned SCORE_W    = 7;
  localparam int unsigned ZONE_OUT_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;

  // Divider shape: dividend holds count * 100, quotient at most 100
  localparam int unsigned DIVIDEND_W = 28;
  localparam int unsigned DIVISOR_W  = 21;
  localparam int unsigned QUOT_W     = 7;

  localparam logic [DIVIDEND_W-1:0] PERCENT   = DIVIDEND_W'(100);
  localparam logic [CNT_W-1:0]      COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [GEOM_W-1:0]     MAX_WIDTH  = GEOM_W'(1024);
  localparam logic [GEOM_W-1:0]     MAX_HEIGHT = GEOM_W'(1024);

  // Register reset values
  localparam logic [PIX_W-1:0]  RST_LUMA_MIN     = PIX_W'(40);
  localparam logic [PIX_W-1:0]  RST_LUMA_MAX     = PIX_W'(200);
  localparam logic [PIX_W-1:0]  RST_BLUE_MAX     = PIX_W'(120);
  localparam logic [PIX_W-1:0]  RST_RED_MAX      = PIX_W'(140);
  localparam logic [PIX_W-1:0]  RST_THRESHOLD    = PIX_W'(30);
  localparam logic [GEOM_W-1:0] RST_STRIP_WIDTH  = GEOM_W'(130);
  localparam logic [GEOM_W-1:0] RST_IMAGE_HEIGHT = GEOM_W'(520);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LUMA_MIN        = 3'd0,
    CFG_LUMA_MAX        = 3'd1,
    CFG_BLUE_CHROMA_MAX = 3'd2,
    CFG_RED_CHROMA_MAX  = 3'd3,
    CFG_BLOCK_THRESHOLD = 3'd4,
    CFG_STRIP_WIDTH     = 3'd5,
    CFG_IMAGE_HEIGHT    = 3'd6
  } cfg_idx_e;

  // Controller to datapath
  typedef struct packed {
    logic pix_load;     // latch accepted pixel
    logic zone_start;   // start row*ZONES/height division
    logic zone_sat;     // row past frame: use the bottom zone
    logic zone_take;    // take zone from divider
    logic count_upd;    // bump counters of the current zone
    logic idx_clr;      // begin frame scoring at zone 0
    logic score_start;  // start flagged*100/total division
    logic score_zero;   // empty zone scores zero
    logic score_take;   // take score from divider
    logic emit;         // load the result register, advance zone
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_strip;
    logic row_past;
    logic frame_end;
    logic div_done;
    logic zone_empty;
    logic zone_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/zngs_divider.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// Requires dividend < divisor << QUOT_W.
module zngs_divider (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [zngs_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  wire logic [zngs_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic                                   done_o,
  output logic [zngs_pkg::QUOT_W-1:0]            quot_o
);

  localparam int unsigned DW  = zngs_pkg::DIVIDEND_W;
  localparam int unsigned QW  = zngs_pkg::QUOT_W;
  localparam int unsigned CW  = $clog2(QW);

  logic [DW-1:0] rem_q, den_q;
  logic [QW-1:0] quot_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic          fits;

  assign fits   = rem_q >= den_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Remainder, shifted divisor and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      den_q  <= DW'(divisor_i) << (QW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - den_q;
      end
      den_q  <= den_q >> 1;
      quot_q <= {quot_q[QW-2:0], fits};
    end
  end

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");

endmodule

`default_nettype wire

[hw/rtl/zngs_datapath.sv]
`default_nettype none

module zngs_datapath #(
  parameter int unsigned ZONES = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration writes
  input  wire logic                               cfg_valid_i,
  input  wire logic [zngs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [zngs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // pixel payload
  input  wire logic [zngs_pkg::IN_DATA_W-1:0]     pix_data_i,
  input  wire logic                               pix_last_i,
  // control
  input  wire zngs_pkg::ctrl_cmd_t                cmd_i,
  output zngs_pkg::dp_status_t                    status_o,
  // results
  output logic                                    res_valid_o,
  input  wire logic                               res_ready_i,
  output logic [zngs_pkg::OUT_DATA_W-1:0]         res_data_o,
  output logic                                    res_last_o
);

  localparam int unsigned ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int unsigned PW = zngs_pkg::PIX_W;
  localparam int unsigned GW = zngs_pkg::GEOM_W;
  localparam int unsigned NW = zngs_pkg::CNT_W;
  localparam int unsigned SW = zngs_pkg::SCORE_W;
  localparam int unsigned OZ = zngs_pkg::ZONE_OUT_W;
  localparam int unsigned DW = zngs_pkg::DIVIDEND_W;
  localparam int unsigned VW = zngs_pkg::DIVISOR_W;
  localparam int unsigned CW = zngs_pkg::COORD_W;

  // Configuration registers
  logic [PW-1:0] luma_min_q, luma_max_q, blue_max_q, red_max_q, thresh_q;
  logic [GW-1:0] strip_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_min_q <= zngs_pkg::RST_LUMA_MIN;
      luma_max_q <= zngs_pkg::RST_LUMA_MAX;
      blue_max_q <= zngs_pkg::RST_BLUE_MAX;
      red_max_q  <= zngs_pkg::RST_RED_MAX;
      thresh_q   <= zngs_pkg::RST_THRESHOLD;
      strip_q    <= zngs_pkg::RST_STRIP_WIDTH;
      height_q   <= zngs_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        zngs_pkg::CFG_LUMA_MIN:        luma_min_q <= cfg_data_i[PW-1:0];
        zngs_pkg::CFG_LUMA_MAX:        luma_max_q <= cfg_data_i[PW-1:0];
        zngs_pkg::CFG_BLUE_CHROMA_MAX: blue_max_q <= cfg_data_i[PW-1:0];
        zngs_pkg::CFG_RED_CHROMA_MAX:  red_max_q  <= cfg_data_i[PW-1:0];
        zngs_pkg::CFG_BLOCK_THRESHOLD: thresh_q   <= cfg_data_i[PW-1:0];
        zngs_pkg::CFG_STRIP_WIDTH:     strip_q    <= cfg_data_i;
        zngs_pkg::CFG_IMAGE_HEIGHT:    height_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched pixel
  logic [PW-1:0] luma_q, cb_q, cr_q;
  logic [CW-1:0] row_q, col_q;
  logic          last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      luma_q <= pix_data_i[7:0];
      cb_q   <= pix_data_i[15:8];
      cr_q   <= pix_data_i[23:16];
      row_q  <= pix_data_i[33:24];
      col_q  <= pix_data_i[43:34];
      last_q <= pix_last_i;
    end
  end

  // Clamped geometry and classification
  logic [GW-1:0] strip_eff, height_eff;
  logic          green;

  always_comb begin
    strip_eff  = strip_q;
    height_eff = height_q;
    if (strip_q == '0) strip_eff = GW'(1);
    if (strip_q > zngs_pkg::MAX_WIDTH) strip_eff = zngs_pkg::MAX_WIDTH;
    if (height_q == '0) height_eff = GW'(1);
    if (height_q > zngs_pkg::MAX_HEIGHT) height_eff = zngs_pkg::MAX_HEIGHT;
  end

  assign green = (luma_q >= luma_min_q) && (luma_q <= luma_max_q) &&
                 (cb_q <= blue_max_q) && (cr_q <= red_max_q);

  // Zone index: pixel zone during counting, scan index during scoring
  logic [ZW-1:0] idx_q;

  // Per-zone counters
  logic [NW-1:0] pix_cnt_q [ZONES];
  logic [NW-1:0] ng_cnt_q  [ZONES];
  logic [NW-1:0] pix_rd, ng_rd;
  logic          zone_last, clear_all;

  assign pix_rd    = pix_cnt_q[idx_q];
  assign ng_rd     = ng_cnt_q[idx_q];
  assign zone_last = idx_q == ZW'(ZONES - 1);
  assign clear_all = cmd_i.emit && zone_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ZONES; i++) begin
        pix_cnt_q[i] <= '0;
        ng_cnt_q[i]  <= '0;
      end
    end else if (clear_all) begin
      for (int i = 0; i < ZONES; i++) begin
        pix_cnt_q[i] <= '0;
        ng_cnt_q[i]  <= '0;
      end
    end else if (cmd_i.count_upd) begin
      if (pix_rd != zngs_pkg::COUNT_MAX) pix_cnt_q[idx_q] <= pix_rd + 1'b1;
      if (!green && ng_rd != zngs_pkg::COUNT_MAX) ng_cnt_q[idx_q] <= ng_rd + 1'b1;
    end
  end

  // Shared divider
  logic [DW-1:0]  div_dividend;
  logic [VW-1:0]  div_divisor;
  logic           div_done;
  logic [SW-1:0]  div_quot;

  always_comb begin
    if (cmd_i.score_start) begin
      div_dividend = DW'(ng_rd) * zngs_pkg::PERCENT;
      div_divisor  = pix_rd;
    end else begin
      div_dividend = DW'(row_q) * DW'(ZONES);
      div_divisor  = VW'(height_eff);
    end
  end

  zngs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.zone_start || cmd_i.score_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr || clear_all) begin
      idx_q <= '0;
    end else if (cmd_i.zone_sat) begin
      idx_q <= ZW'(ZONES - 1);
    end else if (cmd_i.zone_take) begin
      idx_q <= ZW'(div_quot);
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Score and running minimum
  logic [SW-1:0] score_q, best_q, best_d;
  logic [ZW-1:0] safest_q, safest_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.score_zero) begin
      score_q <= '0;
    end else if (cmd_i.score_take) begin
      score_q <= div_quot;
    end
  end

  always_comb begin
    best_d   = best_q;
    safest_d = safest_q;
    if (idx_q == '0 || score_q < best_q) begin
      best_d   = score_q;
      safest_d = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      best_q   <= best_d;
      safest_q <= safest_d;
    end
  end

  // Result register
  logic          out_valid_q, out_last_q, out_blocked_q;
  logic [OZ-1:0] out_zone_q, out_safe_q;
  logic [SW-1:0] out_score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_zone_q    <= OZ'(idx_q);
      out_score_q   <= score_q;
      out_blocked_q <= PW'(score_q) >= thresh_q;
      out_safe_q    <= zone_last ? OZ'(safest_d) : '0;
      out_last_q    <= zone_last;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_last_o  = out_last_q;
  assign res_data_o  = {2'b00, out_safe_q, out_blocked_q, out_score_q, out_zone_q};

  // Status
  assign status_o.in_strip   = GW'(col_q) < strip_eff;
  assign status_o.row_past   = GW'(row_q) >= height_eff;
  assign status_o.frame_end  = last_q;
  assign status_o.div_done   = div_done;
  assign status_o.zone_empty = pix_rd == '0;
  assign status_o.zone_last  = zone_last;
  assign status_o.out_free   = !out_valid_q || res_ready_i;

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_score_q <= SW'(100))
    else $error("score above 100");
  a_ng_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count_upd |-> ng_rd <= pix_rd)
    else $error("non-green count exceeds pixel count");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_all |=> pix_cnt_q[0] == '0 && idx_q == '0)
    else $error("counters not cleared after frame");

endmodule

`default_nettype wire

[hw/rtl/zngs_ctrl.sv]
`default_nettype none

module zngs_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire zngs_pkg::dp_status_t  status_i,
  output zngs_pkg::ctrl_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ZDIV,
    S_UPD,
    S_SLOAD,
    S_SDIV,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  assign in_ready_o = in_ready_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.pix_load = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status_i.in_strip) begin
          cmd_o.idx_clr = status_i.frame_end;
          state_d       = status_i.frame_end ? S_SLOAD : S_IDLE;
        end else if (status_i.row_past) begin
          cmd_o.zone_sat = 1'b1;
          state_d        = S_UPD;
        end else begin
          cmd_o.zone_start = 1'b1;
          state_d          = S_ZDIV;
        end
      end
      S_ZDIV: begin
        if (status_i.div_done) begin
          cmd_o.zone_take = 1'b1;
          state_d         = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.count_upd = 1'b1;
        cmd_o.idx_clr   = status_i.frame_end;
        state_d         = status_i.frame_end ? S_SLOAD : S_IDLE;
      end
      S_SLOAD: begin
        if (status_i.zone_empty) begin
          cmd_o.score_zero = 1'b1;
          state_d          = S_EMIT;
        end else begin
          cmd_o.score_start = 1'b1;
          state_d           = S_SDIV;
        end
      end
      S_SDIV: begin
        if (status_i.div_done) begin
          cmd_o.score_take = 1'b1;
          state_d          = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.zone_last ? S_IDLE : S_SLOAD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= state_d == S_IDLE;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q |-> state_q == S_IDLE)
    else $error("ready outside idle");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("result overwritten");

endmodule

`default_nettype wire

[hw/rtl/zone_non_green_pixel_scorer.sv]
`default_nettype none

// Channel    | Dir | Handshake                    | Payload
// s_axis     | in  | s_axis_tvalid / s_axis_tready| one pixel, tlast = frame end
// m_axis     | out | m_axis_tvalid / m_axis_tready| one zone result, tlast = last zone
// cfg        | in  | cfg_valid_i / cfg_ready_o    | register index and write data
//
// A pixel outside the strip is not counted; a strip pixel below the frame
// goes to the bottom zone; others wait on the 7-step shared divider.
// On frame end each zone scores zero (empty) or runs a score division, plus
// any wait on m_axis; a new pixel is taken while the last result waits.
// Reset (rst_ni, async low) clears counters and loads register defaults.
module zone_non_green_pixel_scorer #(
  parameter int unsigned ZONES = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [zngs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [zngs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // pixels
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: luma[7:0], blue_chroma[15:8], red_chroma[23:16],
  //        row_index[33:24], column_index[43:34], zero[47:44]
  input  wire logic [zngs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  wire logic                             s_axis_tlast,
  // results
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: zone_number[2:0], danger_score[9:3], blocked[10],
  //        safest_zone[13:11], zero[15:14]
  output logic [zngs_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tlast
);

  zngs_pkg::ctrl_cmd_t  cmd;
  zngs_pkg::dp_status_t status;

  // Register writes are always accepted and registered
  assign cfg_ready_o = 1'b1;

  zngs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  zngs_datapath #(
    .ZONES (ZONES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_data_i  (s_axis_tdata),
    .pix_last_i  (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata),
    .res_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
